FILE: hdl/dlrc_pkg.sv
// Package with the types, codes and constants shared by the door lock relay controller.
package dlrc_pkg;

    // Field widths fixed by the item and result formats.
    localparam int NOW_W    = 32;
    localparam int SRC_W    = 4;
    localparam int CODE_W   = 3;
    localparam int CMD_W    = 3;
    localparam int DB_W     = 16;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int MAX_EV   = 3;
    localparam int EV_CNT_W = 2;

    // Reset values of the configuration registers.
    localparam logic [NOW_W-1:0] OPEN_PULSE_RST  = 32'd3000;
    localparam logic             UNLOCK_HIGH_RST = 1'b0;
    localparam logic [DB_W-1:0]  DOOR_DB_RST     = 16'd30;
    localparam logic [DB_W-1:0]  BUTTON_DB_RST   = 16'd50;
    localparam logic [SRC_W-1:0] TRIG_SRC_RST    = 4'd0;

    // Commands carried by an input request.
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK       = 3'd0,
        CMD_OPEN_PULSE = 3'd1,
        CMD_HOLD_ON    = 3'd2,
        CMD_HOLD_OFF   = 3'd3,
        CMD_SECURE     = 3'd4
    } t_cmd;

    // Event codes reported on the result channel.
    typedef enum logic [CODE_W-1:0] {
        EV_NONE         = 3'd0,
        EV_UNLOCKED     = 3'd1,
        EV_LOCKED       = 3'd2,
        EV_DOOR_OPENED  = 3'd3,
        EV_DOOR_CLOSED  = 3'd4,
        EV_EXIT_PRESSED = 3'd5
    } t_event;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OPEN_PULSE_MS = 3'd0,
        CFG_UNLOCK_HIGH   = 3'd1,
        CFG_DOOR_DB_MS    = 3'd2,
        CFG_BUTTON_DB_MS  = 3'd3,
        CFG_TRIG_SOURCE   = 3'd4
    } t_cfg_idx;

    // One classified request: its events in order and the status after it.
    typedef struct packed {
        logic [MAX_EV-1:0][CODE_W-1:0] ev_code;
        logic [MAX_EV-1:0][SRC_W-1:0]  ev_src;
        logic [EV_CNT_W-1:0]           ev_cnt;
        logic                          relay_level;
        logic                          relay_on;
        logic                          door_open;
        logic [NOW_W-1:0]              cycles;
    } t_pkt;

    // Queue status seen by the top level and the back part.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

FILE: hdl/dlrc_fifo.sv
// Short register queue that carries classified requests from the front to the back part.
module dlrc_fifo #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dlrc_pkg::t_pkt  i_wr_data,
    input  logic            i_pop,
    output dlrc_pkg::t_pkt  o_rd_data,
    output dlrc_pkg::t_q_status o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    dlrc_pkg::t_pkt   r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset; the fill count guards every read.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    assign o_rd_data       = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == CW'(DEPTH));
    assign o_status.empty  = (r_count == '0);

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full |-> !i_push)
        else $error("request pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.empty |-> !i_pop)
        else $error("request popped from an empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue fill count beyond its depth");

endmodule

FILE: hdl/dlrc_front.sv
// Front part: configuration registers, lock and debounce state, and request classification.
module dlrc_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [dlrc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dlrc_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         i_accept,
    input  logic [dlrc_pkg::CMD_W-1:0]   i_cmd,
    input  logic [dlrc_pkg::NOW_W-1:0]   i_now_ms,
    input  logic [dlrc_pkg::SRC_W-1:0]   i_open_source,
    input  logic                         i_door_pin,
    input  logic                         i_button_pin,
    output dlrc_pkg::t_pkt               o_pkt
);

    localparam int NW = dlrc_pkg::NOW_W;
    localparam int DW = dlrc_pkg::DB_W;

    // Configuration registers.
    logic [NW-1:0]              r_open_pulse_ms;
    logic                       r_unlock_high;
    logic [DW-1:0]              r_door_db_ms;
    logic [DW-1:0]              r_button_db_ms;
    logic [dlrc_pkg::SRC_W-1:0] r_trig_source;

    // Lock and debounce state.
    logic          r_relay_active,   n_relay_active;
    logic          r_hold_active,    n_hold_active;
    logic          r_pulse_pending,  n_pulse_pending;
    logic [NW-1:0] r_pulse_deadline, n_pulse_deadline;
    logic          r_door_sample,    n_door_sample;
    logic [NW-1:0] r_door_time,      n_door_time;
    logic          r_door_stable,    n_door_stable;
    logic          r_button_sample,  n_button_sample;
    logic [NW-1:0] r_button_time,    n_button_time;
    logic          r_button_stable,  n_button_stable;
    logic [NW-1:0] r_cycles,         n_cycles;

    // Timing terms of a tick.
    logic [NW-1:0] pulse_diff;
    logic          pulse_due;
    logic [NW-1:0] door_time;
    logic [NW-1:0] door_elapsed;
    logic          door_settled;
    logic [NW-1:0] button_time;
    logic [NW-1:0] button_elapsed;
    logic          button_settled;

    // Events collected for this request.
    logic [dlrc_pkg::MAX_EV-1:0][dlrc_pkg::CODE_W-1:0] ev_code;
    logic [dlrc_pkg::MAX_EV-1:0][dlrc_pkg::SRC_W-1:0]  ev_src;
    logic [dlrc_pkg::EV_CNT_W-1:0]                     ev_cnt;

    // Configuration writes; indexes outside the register list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_pulse_ms <= dlrc_pkg::OPEN_PULSE_RST;
            r_unlock_high   <= dlrc_pkg::UNLOCK_HIGH_RST;
            r_door_db_ms    <= dlrc_pkg::DOOR_DB_RST;
            r_button_db_ms  <= dlrc_pkg::BUTTON_DB_RST;
            r_trig_source   <= dlrc_pkg::TRIG_SRC_RST;
        end else if (i_cfg_valid) begin
            unique case (dlrc_pkg::t_cfg_idx'(i_cfg_index))
                dlrc_pkg::CFG_OPEN_PULSE_MS: r_open_pulse_ms <= i_cfg_data[NW-1:0];
                dlrc_pkg::CFG_UNLOCK_HIGH:   r_unlock_high   <= i_cfg_data[0];
                dlrc_pkg::CFG_DOOR_DB_MS:    r_door_db_ms    <= i_cfg_data[DW-1:0];
                dlrc_pkg::CFG_BUTTON_DB_MS:  r_button_db_ms  <= i_cfg_data[DW-1:0];
                dlrc_pkg::CFG_TRIG_SOURCE:
                    r_trig_source <= i_cfg_data[dlrc_pkg::SRC_W-1:0];
                default: ;
            endcase
        end
    end

    // Wrap-safe deadline test and debounce timers.
    always_comb begin
        pulse_diff     = i_now_ms - r_pulse_deadline;
        pulse_due      = r_pulse_pending && !r_hold_active && !pulse_diff[NW-1];
        door_time      = (i_door_pin != r_door_sample) ? i_now_ms : r_door_time;
        door_elapsed   = i_now_ms - door_time;
        door_settled   = (i_door_pin != r_door_stable) &&
                         (door_elapsed >= {{(NW-DW){1'b0}}, r_door_db_ms});
        button_time    = (i_button_pin != r_button_sample) ? i_now_ms : r_button_time;
        button_elapsed = i_now_ms - button_time;
        button_settled = (i_button_pin != r_button_stable) &&
                         (button_elapsed >= {{(NW-DW){1'b0}}, r_button_db_ms});
    end

    // Command decode: next state and the ordered list of events.
    always_comb begin
        n_relay_active   = r_relay_active;
        n_hold_active    = r_hold_active;
        n_pulse_pending  = r_pulse_pending;
        n_pulse_deadline = r_pulse_deadline;
        n_door_sample    = r_door_sample;
        n_door_time      = r_door_time;
        n_door_stable    = r_door_stable;
        n_button_sample  = r_button_sample;
        n_button_time    = r_button_time;
        n_button_stable  = r_button_stable;
        n_cycles         = r_cycles;
        ev_code          = '0;
        ev_src           = '0;
        ev_cnt           = '0;

        unique case (dlrc_pkg::t_cmd'(i_cmd))
            dlrc_pkg::CMD_TICK: begin
                // Pulse end comes first, then the door, then the button.
                if (pulse_due) begin
                    n_pulse_pending = 1'b0;
                    if (r_relay_active) begin
                        n_relay_active  = 1'b0;
                        n_cycles        = r_cycles + NW'(1);
                        ev_code[ev_cnt] = dlrc_pkg::EV_LOCKED;
                        ev_cnt          = ev_cnt + 2'd1;
                    end
                end
                n_door_sample = i_door_pin;
                n_door_time   = door_time;
                if (door_settled) begin
                    n_door_stable   = i_door_pin;
                    ev_code[ev_cnt] = i_door_pin ? dlrc_pkg::EV_DOOR_OPENED
                                                 : dlrc_pkg::EV_DOOR_CLOSED;
                    ev_cnt          = ev_cnt + 2'd1;
                end
                n_button_sample = i_button_pin;
                n_button_time   = button_time;
                if (button_settled) begin
                    n_button_stable = i_button_pin;
                    if (!i_button_pin) begin
                        ev_code[ev_cnt] = dlrc_pkg::EV_EXIT_PRESSED;
                        ev_cnt          = ev_cnt + 2'd1;
                    end
                end
            end
            dlrc_pkg::CMD_OPEN_PULSE: begin
                n_relay_active   = 1'b1;
                n_pulse_pending  = 1'b1;
                n_pulse_deadline = i_now_ms + r_open_pulse_ms;
                ev_code[0]       = dlrc_pkg::EV_UNLOCKED;
                ev_src[0]        = i_open_source;
                ev_cnt           = 2'd1;
            end
            dlrc_pkg::CMD_HOLD_ON: begin
                n_hold_active   = 1'b1;
                n_relay_active  = 1'b1;
                n_pulse_pending = 1'b0;
                ev_code[0]      = dlrc_pkg::EV_UNLOCKED;
                ev_src[0]       = r_trig_source;
                ev_cnt          = 2'd1;
            end
            dlrc_pkg::CMD_HOLD_OFF: begin
                n_hold_active   = 1'b0;
                n_pulse_pending = 1'b0;
                if (r_relay_active) begin
                    n_relay_active = 1'b0;
                    n_cycles       = r_cycles + NW'(1);
                    ev_code[0]     = dlrc_pkg::EV_LOCKED;
                    ev_cnt         = 2'd1;
                end
            end
            dlrc_pkg::CMD_SECURE: begin
                // Emergency secure engages the lock without a locked event.
                n_hold_active   = 1'b0;
                n_pulse_pending = 1'b0;
                n_relay_active  = 1'b0;
            end
            default: ;
        endcase

        // A request with no event still reports status once.
        if (ev_cnt == '0) begin
            ev_code[0] = dlrc_pkg::EV_NONE;
            ev_src[0]  = '0;
            ev_cnt     = 2'd1;
        end
    end

    // State advances only on an accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relay_active   <= 1'b0;
            r_hold_active    <= 1'b0;
            r_pulse_pending  <= 1'b0;
            r_pulse_deadline <= '0;
            r_door_sample    <= 1'b0;
            r_door_time      <= '0;
            r_door_stable    <= 1'b0;
            r_button_sample  <= 1'b1;
            r_button_time    <= '0;
            r_button_stable  <= 1'b1;
            r_cycles         <= '0;
        end else if (i_accept) begin
            r_relay_active   <= n_relay_active;
            r_hold_active    <= n_hold_active;
            r_pulse_pending  <= n_pulse_pending;
            r_pulse_deadline <= n_pulse_deadline;
            r_door_sample    <= n_door_sample;
            r_door_time      <= n_door_time;
            r_door_stable    <= n_door_stable;
            r_button_sample  <= n_button_sample;
            r_button_time    <= n_button_time;
            r_button_stable  <= n_button_stable;
            r_cycles         <= n_cycles;
        end
    end

    // Classified request handed to the queue.
    always_comb begin
        o_pkt.ev_code     = ev_code;
        o_pkt.ev_src      = ev_src;
        o_pkt.ev_cnt      = ev_cnt;
        o_pkt.relay_level = n_relay_active ? r_unlock_high : ~r_unlock_high;
        o_pkt.relay_on    = n_relay_active;
        o_pkt.door_open   = n_door_stable;
        o_pkt.cycles      = n_cycles;
    end

endmodule

FILE: hdl/dlrc_back.sv
// Back part: walks the events of each queued request and drives the registered result port.
module dlrc_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dlrc_pkg::t_pkt               i_head,
    input  dlrc_pkg::t_q_status          i_q_status,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [dlrc_pkg::CODE_W-1:0]  o_event_code,
    output logic [dlrc_pkg::SRC_W-1:0]   o_event_source,
    output logic                         o_relay_level,
    output logic                         o_relay_on,
    output logic                         o_door_is_open,
    output logic [dlrc_pkg::NOW_W-1:0]   o_cycles_done,
    output logic                         o_last
);

    logic                          r_valid, n_valid;
    logic [dlrc_pkg::EV_CNT_W-1:0] r_idx,   n_idx;
    logic                          load;
    logic                          final_ev;

    // Result payload registers.
    logic [dlrc_pkg::CODE_W-1:0] r_event_code;
    logic [dlrc_pkg::SRC_W-1:0]  r_event_source;
    logic                        r_relay_level;
    logic                        r_relay_on;
    logic                        r_door_is_open;
    logic [dlrc_pkg::NOW_W-1:0]  r_cycles_done;
    logic                        r_last;

    // A new result loads when the output register is empty or being taken.
    always_comb begin
        load     = !i_q_status.empty && (!r_valid || !i_stall);
        final_ev = (r_idx == i_head.ev_cnt - 2'd1);
        o_pop    = load && final_ev;
        n_idx    = r_idx;
        if (load) begin
            n_idx = final_ev ? '0 : r_idx + 2'd1;
        end
        if (load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_event_code   <= i_head.ev_code[r_idx];
            r_event_source <= i_head.ev_src[r_idx];
            r_relay_level  <= i_head.relay_level;
            r_relay_on     <= i_head.relay_on;
            r_door_is_open <= i_head.door_open;
            r_cycles_done  <= i_head.cycles;
            r_last         <= final_ev;
        end
    end

    assign o_valid        = r_valid;
    assign o_event_code   = r_event_code;
    assign o_event_source = r_event_source;
    assign o_relay_level  = r_relay_level;
    assign o_relay_on     = r_relay_on;
    assign o_door_is_open = r_door_is_open;
    assign o_cycles_done  = r_cycles_done;
    assign o_last         = r_last;

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_status.empty |-> (r_idx < i_head.ev_cnt))
        else $error("event index beyond the events of the queued request");

    a_idx_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_status.empty |-> (r_idx == '0))
        else $error("event index left mid-request with an empty queue");

endmodule

FILE: hdl/door_lock_relay_controller.sv
// Top level of the door lock relay controller: front, request queue and back.
//
// Usage: each input request carries a command, a millisecond timestamp, an open
// source and the raw door and exit-button levels; it is taken at a rising edge
// with i_valid high and o_stall low. Each request yields one to three results
// on the output channel, taken at an edge with o_valid high and i_stall low;
// o_last marks the final result of a request.
// Accepted requests wait in the queue; the single result register takes their
// results from the queue head one after another, loading a new one when it is
// empty or being taken. The front classifies a request in its accept cycle and
// places it in a short queue, so requests keep being accepted while the
// receiver stalls until the queue is full, at which point o_stall rises.
// Configuration writes use i_cfg_valid, o_cfg_ready, i_cfg_index and
// i_cfg_data, are always ready, and the user must see that they are made only
// while no request is in flight; the block does not enforce this. Reset
// (synchronous, active low) locks the relay, clears hold and pulse, takes the
// door as closed and the button as released, zeroes the cycle count, restores
// the register defaults and empties the queue.
module door_lock_relay_controller #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dlrc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dlrc_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [dlrc_pkg::CMD_W-1:0]     i_cmd,
    input  logic [dlrc_pkg::NOW_W-1:0]     i_now_ms,
    input  logic [dlrc_pkg::SRC_W-1:0]     i_open_source,
    input  logic                           i_door_pin,
    input  logic                           i_button_pin,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [dlrc_pkg::CODE_W-1:0]    o_event_code,
    output logic [dlrc_pkg::SRC_W-1:0]     o_event_source,
    output logic                           o_relay_level,
    output logic                           o_relay_on,
    output logic                           o_door_is_open,
    output logic [dlrc_pkg::NOW_W-1:0]     o_cycles_done,
    output logic                           o_last
);

    dlrc_pkg::t_pkt      front_pkt;
    dlrc_pkg::t_pkt      head_pkt;
    dlrc_pkg::t_q_status q_status;
    logic                accept;
    logic                pop;

    // Requests are taken whenever the queue has room.
    assign o_stall     = q_status.full;
    assign accept      = i_valid && !q_status.full;
    assign o_cfg_ready = 1'b1;

    dlrc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_cmd         (i_cmd),
        .i_now_ms      (i_now_ms),
        .i_open_source (i_open_source),
        .i_door_pin    (i_door_pin),
        .i_button_pin  (i_button_pin),
        .o_pkt         (front_pkt)
    );

    dlrc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (accept),
        .i_wr_data (front_pkt),
        .i_pop     (pop),
        .o_rd_data (head_pkt),
        .o_status  (q_status)
    );

    dlrc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head_pkt),
        .i_q_status     (q_status),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_event_code   (o_event_code),
        .o_event_source (o_event_source),
        .o_relay_level  (o_relay_level),
        .o_relay_on     (o_relay_on),
        .o_door_is_open (o_door_is_open),
        .o_cycles_done  (o_cycles_done),
        .o_last         (o_last)
    );

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the door lock relay controller.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NW = dlrc_pkg::NOW_W;
    localparam int SW = dlrc_pkg::SRC_W;
    localparam int EW = dlrc_pkg::CODE_W;
    localparam int MW = dlrc_pkg::CMD_W;
    localparam int DW = dlrc_pkg::DB_W;
    localparam int XW = dlrc_pkg::CFG_IDX_W;
    localparam int FW = dlrc_pkg::CFG_W;

    localparam int N_DIRECTED   = 26;
    localparam int N_PHASES     = 5;
    localparam int PHASE_ITEMS  = 49;
    localparam int LONG_HOLD    = 60;
    localparam int CYCLE_LIMIT  = 200000;

    // One expected result: the event and the status after the request.
    typedef struct {
        logic [EW-1:0] code;
        logic [SW-1:0] src;
        logic          level;
        logic          released;
        logic          door_open;
        logic [NW-1:0] cycles;
        logic          last;
    } t_lock_result;

    typedef struct {
        dlrc_pkg::t_event code;
        logic [SW-1:0]    src;
    } t_lock_event;

    // A directed request, with an event typed in where it is obvious.
    typedef struct {
        logic [MW-1:0]    cmd;
        logic [NW-1:0]    now;
        logic [SW-1:0]    src;
        logic             door;
        logic             button;
        logic             typed;
        dlrc_pkg::t_event code;
        logic [SW-1:0]    esrc;
    } t_directed_row;

    // Register settings and traffic shape of one random phase.
    typedef struct {
        logic [NW-1:0] pulse_ms;
        logic          unlock_high;
        logic [DW-1:0] door_db;
        logic [DW-1:0] button_db;
        logic [SW-1:0] trig_src;
        int unsigned   step_max;
        bit            tx_gaps;
        bit            rx_gaps;
    } t_phase;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [XW-1:0] i_cfg_index;
    logic [FW-1:0] i_cfg_data;
    logic          i_valid;
    logic          o_stall;
    logic [MW-1:0] i_cmd;
    logic [NW-1:0] i_now_ms;
    logic [SW-1:0] i_open_source;
    logic          i_door_pin;
    logic          i_button_pin;
    logic          o_valid;
    logic          i_stall;
    logic [EW-1:0] o_event_code;
    logic [SW-1:0] o_event_source;
    logic          o_relay_level;
    logic          o_relay_on;
    logic          o_door_is_open;
    logic [NW-1:0] o_cycles_done;
    logic          o_last;

    // Typed expectation travelling alongside the request payload.
    logic             dir_typed;
    dlrc_pkg::t_event dir_code;
    logic [SW-1:0]    dir_src;

    // Shadow registers and state of the lock.
    logic [NW-1:0] cfg_pulse_ms;
    logic          cfg_unlock_high;
    logic [DW-1:0] cfg_door_db;
    logic [DW-1:0] cfg_button_db;
    logic [SW-1:0] cfg_trig_src;
    logic          relay_released;
    logic          hold_set;
    logic          pulse_armed;
    logic [NW-1:0] pulse_due_ms;
    logic          door_raw_last;
    logic [NW-1:0] door_raw_since;
    logic          door_settled;
    logic          button_raw_last;
    logic [NW-1:0] button_raw_since;
    logic          button_settled;
    logic [NW-1:0] lock_cycles;

    t_lock_event  step_events[$];
    t_lock_result lock_results[$];
    int           first_idx;
    int           err_count = 0;
    int           watch_cycles = 0;
    bit           tx_gaps = 1'b1;
    bit           rx_gaps = 1'b1;
    bit           hold_off_req = 1'b0;

    t_directed_row directed_rows [0:N_DIRECTED-1];
    t_phase        phases [0:N_PHASES-1];

    door_lock_relay_controller DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_now_ms       (i_now_ms),
        .i_open_source  (i_open_source),
        .i_door_pin     (i_door_pin),
        .i_button_pin   (i_button_pin),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_event_code   (o_event_code),
        .o_event_source (o_event_source),
        .o_relay_level  (o_relay_level),
        .o_relay_on     (o_relay_on),
        .o_door_is_open (o_door_is_open),
        .o_cycles_done  (o_cycles_done),
        .o_last         (o_last)
    );

    always #5ns i_clk = ~i_clk;

    // Put the lock model back to its state after reset.
    function automatic void reset_lock_model();
        cfg_pulse_ms     = dlrc_pkg::OPEN_PULSE_RST;
        cfg_unlock_high  = dlrc_pkg::UNLOCK_HIGH_RST;
        cfg_door_db      = dlrc_pkg::DOOR_DB_RST;
        cfg_button_db    = dlrc_pkg::BUTTON_DB_RST;
        cfg_trig_src     = dlrc_pkg::TRIG_SRC_RST;
        relay_released   = 1'b0;
        hold_set         = 1'b0;
        pulse_armed      = 1'b0;
        pulse_due_ms     = '0;
        door_raw_last    = 1'b0;
        door_raw_since   = '0;
        door_settled     = 1'b0;
        button_raw_last  = 1'b1;
        button_raw_since = '0;
        button_settled   = 1'b1;
        lock_cycles      = '0;
        lock_results.delete();
    endfunction

    function automatic void note_event(dlrc_pkg::t_event code, logic [SW-1:0] src);
        t_lock_event e;
        e.code = code;
        e.src  = src;
        if (step_events.size() < dlrc_pkg::MAX_EV)
            step_events.push_back(e);
    endfunction

    // Engage the lock at the end of a pulse or on hold off; only a release counts.
    function automatic void finish_open_pulse();
        pulse_armed = 1'b0;
        if (relay_released) begin
            relay_released = 1'b0;
            note_event(dlrc_pkg::EV_LOCKED, '0);
            lock_cycles = lock_cycles + NW'(1);
        end
    endfunction

    // Work out the results of one accepted request and queue them.
    function automatic void predict_lock_step(logic [MW-1:0] cmd, logic [NW-1:0] now,
                                              logic [SW-1:0] src, logic door, logic btn);
        t_lock_result r;
        logic [NW-1:0] lead;
        logic [NW-1:0] age;
        step_events.delete();
        case (cmd)
            dlrc_pkg::CMD_TICK: begin
                // Pulse end comes first, then the door, then the button.
                lead = now - pulse_due_ms;
                if (pulse_armed && !hold_set && !lead[NW-1])
                    finish_open_pulse();
                if (door != door_raw_last) begin
                    door_raw_last  = door;
                    door_raw_since = now;
                end
                age = now - door_raw_since;
                if (door != door_settled && age >= {16'd0, cfg_door_db}) begin
                    door_settled = door;
                    if (door)
                        note_event(dlrc_pkg::EV_DOOR_OPENED, '0);
                    else
                        note_event(dlrc_pkg::EV_DOOR_CLOSED, '0);
                end
                if (btn != button_raw_last) begin
                    button_raw_last  = btn;
                    button_raw_since = now;
                end
                age = now - button_raw_since;
                if (btn != button_settled && age >= {16'd0, cfg_button_db}) begin
                    button_settled = btn;
                    if (!btn)
                        note_event(dlrc_pkg::EV_EXIT_PRESSED, '0);
                end
            end
            dlrc_pkg::CMD_OPEN_PULSE: begin
                relay_released = 1'b1;
                pulse_armed    = 1'b1;
                pulse_due_ms   = now + cfg_pulse_ms;
                note_event(dlrc_pkg::EV_UNLOCKED, src);
            end
            dlrc_pkg::CMD_HOLD_ON: begin
                hold_set       = 1'b1;
                relay_released = 1'b1;
                pulse_armed    = 1'b0;
                note_event(dlrc_pkg::EV_UNLOCKED, cfg_trig_src);
            end
            dlrc_pkg::CMD_HOLD_OFF: begin
                hold_set = 1'b0;
                finish_open_pulse();
            end
            dlrc_pkg::CMD_SECURE: begin
                hold_set       = 1'b0;
                pulse_armed    = 1'b0;
                relay_released = 1'b0;
            end
            default: ;
        endcase
        if (step_events.size() == 0)
            note_event(dlrc_pkg::EV_NONE, '0);

        // Status fields are the same on every result of the request.
        foreach (step_events[k]) begin
            r.code      = step_events[k].code;
            r.src       = step_events[k].src;
            r.level     = relay_released ? cfg_unlock_high : ~cfg_unlock_high;
            r.released  = relay_released;
            r.door_open = door_settled;
            r.cycles    = lock_cycles;
            r.last      = (k == step_events.size() - 1);
            lock_results.push_back(r);
        end
    endfunction

    function automatic void compare_field(string name, logic [NW-1:0] want,
                                          logic [NW-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_count++;
        end
    endfunction

    // Register writes, prediction of accepted requests and checking of results.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_lock_model();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    dlrc_pkg::CFG_OPEN_PULSE_MS: cfg_pulse_ms    = i_cfg_data;
                    dlrc_pkg::CFG_UNLOCK_HIGH:   cfg_unlock_high = i_cfg_data[0];
                    dlrc_pkg::CFG_DOOR_DB_MS:    cfg_door_db     = i_cfg_data[DW-1:0];
                    dlrc_pkg::CFG_BUTTON_DB_MS:  cfg_button_db   = i_cfg_data[DW-1:0];
                    dlrc_pkg::CFG_TRIG_SOURCE:   cfg_trig_src    = i_cfg_data[SW-1:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                first_idx = lock_results.size();
                predict_lock_step(i_cmd, i_now_ms, i_open_source, i_door_pin, i_button_pin);
                if (dir_typed) begin
                    lock_results[first_idx].code = dir_code;
                    lock_results[first_idx].src  = dir_src;
                end
            end
            if (o_valid && !i_stall) begin
                if (lock_results.size() == 0) begin
                    $error("result with no request waiting: event_code %0d", o_event_code);
                    err_count++;
                end else begin
                    compare_field("event_code", NW'(lock_results[0].code),
                                  NW'(o_event_code));
                    compare_field("event_source", NW'(lock_results[0].src),
                                  NW'(o_event_source));
                    compare_field("relay_level", NW'(lock_results[0].level),
                                  NW'(o_relay_level));
                    compare_field("relay_on", NW'(lock_results[0].released),
                                  NW'(o_relay_on));
                    compare_field("door_is_open", NW'(lock_results[0].door_open),
                                  NW'(o_door_is_open));
                    compare_field("cycles_done", lock_results[0].cycles, o_cycles_done);
                    compare_field("last", NW'(lock_results[0].last), NW'(o_last));
                    void'(lock_results.pop_front());
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        watch_cycles++;
        if (watch_cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: short stall bursts, and one long hold-off on request.
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Offer one request and return at the edge that takes it; valid stays high.
    task automatic send_request(logic [MW-1:0] cmd, logic [NW-1:0] now,
                                logic [SW-1:0] src, logic door, logic btn,
                                logic typed, dlrc_pkg::t_event code, logic [SW-1:0] esrc);
        i_valid       <= 1'b1;
        i_cmd         <= cmd;
        i_now_ms      <= now;
        i_open_source <= src;
        i_door_pin    <= door;
        i_button_pin  <= btn;
        dir_typed     <= typed;
        dir_code      <= code;
        dir_src       <= esrc;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic sender_gap();
        if (tx_gaps && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (lock_results.size() != 0);
    endtask

    // Write one register; the caller lowers the write valid after the last one.
    task automatic write_reg(dlrc_pkg::t_cfg_idx idx, logic [FW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    initial begin
        logic [NW-1:0] now_cursor;
        logic          door_level;
        logic          button_level;
        logic [MW-1:0] cmd;
        int            pick;
        int            counted;

        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        i_valid       <= 1'b0;
        i_cmd         <= '0;
        i_now_ms      <= '0;
        i_open_source <= '0;
        i_door_pin    <= 1'b0;
        i_button_pin  <= 1'b1;
        dir_typed     <= 1'b0;
        dir_code      <= dlrc_pkg::EV_NONE;
        dir_src       <= '0;

        // Directed requests at the reset register values.
        directed_rows = '{
            '{dlrc_pkg::CMD_TICK,       32'd0,         4'd0,  1'b0, 1'b1,
              1'b1, dlrc_pkg::EV_NONE,     4'd0},
            '{3'd5,                     32'd0,         4'd15, 1'b1, 1'b0,
              1'b1, dlrc_pkg::EV_NONE,     4'd0},
            '{3'd6,                     32'd0,         4'd15, 1'b1, 1'b0,
              1'b1, dlrc_pkg::EV_NONE,     4'd0},
            '{3'd7,                     32'd0,         4'd15, 1'b1, 1'b0,
              1'b1, dlrc_pkg::EV_NONE,     4'd0},
            '{dlrc_pkg::CMD_OPEN_PULSE, 32'd100,       4'd15, 1'b0, 1'b1,
              1'b1, dlrc_pkg::EV_UNLOCKED, 4'd15},
            '{dlrc_pkg::CMD_TICK,       32'd3099,      4'd0,  1'b0, 1'b1,
              1'b0, dlrc_pkg::EV_NONE,     4'd0},
            '{dlrc_pkg::CMD_TICK,       32'd3100,      4'd0,  1'b0, 1'b1,
              1'b1, dlrc_pkg::EV_LOCKED,   4'd0},
            '{dlrc_pkg::CMD_HOLD_OFF,   32'd3200,      4'd0,  1'b0, 1'b1,
              1'b1, dlrc_pkg::EV_NONE,     4'd0},
            '{dlrc_pkg::CMD_HOLD_ON,    32'd3300,      4'd7,  1'b0, 1'b1,
              1'b1, dlrc_pkg::EV_UNLOCKED, 4'd0},
            '{dlrc_pkg::CMD_OPEN_PULSE, 32'd3400,      4'd5,  1'b0, 1'b1,
              1'b1, dlrc_pkg::EV_UNLOCKED, 4'd5},
            '{dlrc_pkg::CMD_TICK,       32'd9000,      4'd0,  1'b0, 1'b1,
              1'b0, dlrc_pkg::EV_NONE,     4'd0},
            '{dlrc_pkg::CMD_HOLD_OFF,   32'd9100,      4'd0,  1'b0, 1'b1,
              1'b1, dlrc_pkg::EV_LOCKED,   4'd0},
            '{dlrc_pkg::CMD_OPEN_PULSE, 32'd9200,      4'd0,  1'b0, 1'b1,
              1'b1, dlrc_pkg::EV_UNLOCKED, 4'd0},
            '{dlrc_pkg::CMD_SECURE,     32'd9300,      4'd0,  1'b0, 1'b1,
              1'b1, dlrc_pkg::EV_NONE,     4'd0},
            '{dlrc_pkg::CMD_TICK,       32'd20000,     4'd0,  1'b0, 1'b1,
              1'b0, dlrc_pkg::EV_NONE,     4'd0},
            // Deadline lands exactly on zero.
            '{dlrc_pkg::CMD_OPEN_PULSE, 32'hFFFF_F448, 4'd10, 1'b0, 1'b1,
              1'b1, dlrc_pkg::EV_UNLOCKED, 4'd10},
            '{dlrc_pkg::CMD_TICK,       32'hFFFF_FFFF, 4'd0,  1'b0, 1'b1,
              1'b0, dlrc_pkg::EV_NONE,     4'd0},
            '{dlrc_pkg::CMD_TICK,       32'd0,         4'd0,  1'b0, 1'b1,
              1'b0, dlrc_pkg::EV_NONE,     4'd0},
            // Deadline wraps past the top of the timestamp range.
            '{dlrc_pkg::CMD_OPEN_PULSE, 32'hFFFF_FF00, 4'd3,  1'b0, 1'b1,
              1'b0, dlrc_pkg::EV_NONE,     4'd0},
            '{dlrc_pkg::CMD_TICK,       32'h0000_0010, 4'd0,  1'b0, 1'b1,
              1'b0, dlrc_pkg::EV_NONE,     4'd0},
            '{dlrc_pkg::CMD_TICK,       32'h0000_0AB8, 4'd0,  1'b0, 1'b1,
              1'b0, dlrc_pkg::EV_NONE,     4'd0},
            // Pulse end, door opened and exit pressed on the same tick.
            '{dlrc_pkg::CMD_OPEN_PULSE, 32'd2060,      4'd1,  1'b0, 1'b1,
              1'b0, dlrc_pkg::EV_NONE,     4'd0},
            '{dlrc_pkg::CMD_TICK,       32'd5000,      4'd0,  1'b1, 1'b0,
              1'b0, dlrc_pkg::EV_NONE,     4'd0},
            '{dlrc_pkg::CMD_TICK,       32'd5060,      4'd0,  1'b1, 1'b0,
              1'b0, dlrc_pkg::EV_NONE,     4'd0},
            '{dlrc_pkg::CMD_TICK,       32'd6000,      4'd0,  1'b0, 1'b1,
              1'b0, dlrc_pkg::EV_NONE,     4'd0},
            '{dlrc_pkg::CMD_TICK,       32'd6100,      4'd0,  1'b0, 1'b1,
              1'b0, dlrc_pkg::EV_NONE,     4'd0}
        };

        // Register settings per random phase, extremes first.
        phases = '{
            '{32'd20,        1'b1, 16'd0,     16'd0,     4'd15, 8,     1'b1, 1'b1},
            '{32'd0,         1'b0, 16'hFFFF,  16'hFFFF,  4'd0,  40000, 1'b0, 1'b1},
            '{32'hFFFF_FFFF, 1'b1, 16'd5,     16'd7,     4'd9,  6,     1'b1, 1'b1},
            '{32'd100,       1'b0, 16'd20,    16'd20,    4'd3,  30,    1'b1, 1'b0},
            '{32'd100,       1'b0, 16'd3,     16'd3,     4'd6,  20,    1'b0, 1'b0}
        };
        phases[3].pulse_ms    = $urandom_range(1, 300);
        phases[3].unlock_high = 1'($urandom_range(0, 1));
        phases[3].door_db     = DW'($urandom_range(0, 60));
        phases[3].button_db   = DW'($urandom_range(0, 60));
        phases[3].trig_src    = SW'($urandom_range(0, 15));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part.
        foreach (directed_rows[n]) begin
            send_request(directed_rows[n].cmd, directed_rows[n].now, directed_rows[n].src,
                         directed_rows[n].door, directed_rows[n].button,
                         directed_rows[n].typed, directed_rows[n].code, directed_rows[n].esrc);
            sender_gap();
        end

        // Random phases, each behind a fresh register setting.
        now_cursor   = 32'd7000;
        door_level   = 1'b0;
        button_level = 1'b1;
        for (int p = 0; p < N_PHASES; p++) begin
            drain_results();
            write_reg(dlrc_pkg::CFG_OPEN_PULSE_MS, phases[p].pulse_ms);
            write_reg(dlrc_pkg::CFG_UNLOCK_HIGH, {31'd0, phases[p].unlock_high});
            write_reg(dlrc_pkg::CFG_DOOR_DB_MS, {16'd0, phases[p].door_db});
            write_reg(dlrc_pkg::CFG_BUTTON_DB_MS, {16'd0, phases[p].button_db});
            write_reg(dlrc_pkg::CFG_TRIG_SOURCE, {28'd0, phases[p].trig_src});
            i_cfg_valid <= 1'b0;
            tx_gaps = phases[p].tx_gaps;
            rx_gaps = phases[p].rx_gaps;
            // The result side holds off while requests keep coming, to fill the queue.
            if (p == 1)
                hold_off_req = 1'b1;

            counted = 0;
            while (counted < PHASE_ITEMS) begin
                if (p == 3 && counted == PHASE_ITEMS / 2)
                    drain_results();
                pick = $urandom_range(0, 99);
                if (pick < 65)
                    cmd = dlrc_pkg::CMD_TICK;
                else if (pick < 75)
                    cmd = dlrc_pkg::CMD_OPEN_PULSE;
                else if (pick < 82)
                    cmd = dlrc_pkg::CMD_HOLD_ON;
                else if (pick < 89)
                    cmd = dlrc_pkg::CMD_HOLD_OFF;
                else if (pick < 95)
                    cmd = dlrc_pkg::CMD_SECURE;
                else
                    cmd = MW'($urandom_range(5, 7));

                // Mostly steady time, now and then a jump anywhere in the range.
                if ($urandom_range(0, 29) == 0)
                    now_cursor = $urandom;
                else
                    now_cursor = now_cursor + $urandom_range(0, phases[p].step_max);

                // Pins hold their level for runs, with the odd one-request glitch.
                if ($urandom_range(0, 7) == 0)
                    door_level = ~door_level;
                if ($urandom_range(0, 7) == 0)
                    button_level = ~button_level;

                send_request(cmd, now_cursor, SW'($urandom_range(0, 15)),
                             door_level ^ ($urandom_range(0, 11) == 0),
                             button_level ^ ($urandom_range(0, 11) == 0),
                             1'b0, dlrc_pkg::EV_NONE, 4'd0);
                if (cmd <= dlrc_pkg::CMD_SECURE)
                    counted++;
                sender_gap();
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
